// File: src/vbp_pkg.sv
// ----------------------------------------------------------------------------
// vbp_pkg
// Shared types and constants of the variable bit packer.
// ----------------------------------------------------------------------------
package vbp_pkg;

    // Item kinds carried on the input tuser bit
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_FLUSH = 1'b1;

    localparam int VALUE_W    = 32;
    localparam int BIT_COUNT_W = 6;
    localparam int BYTE_W     = 8;

    // Input tdata: field_value, bit_count, msb_first, padded to whole bytes
    localparam int IN_FIELDS_W = VALUE_W + BIT_COUNT_W + 1;
    localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;

    localparam int MAX_FIELD_BITS_DEF = 32;

    typedef struct packed {
        logic                   func;
        logic [VALUE_W-1:0]     field_value;
        logic [BIT_COUNT_W-1:0] bit_count;
        logic                   msb_first;
    } t_in_item;

endpackage

// File: src/vbp_in_stage.sv
// ----------------------------------------------------------------------------
// vbp_in_stage
// Input register: holds one accepted item until the packing core takes it.
// ----------------------------------------------------------------------------
module vbp_in_stage
    import vbp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_in_item i_item,
    input  logic     i_take,
    output logic     o_valid,
    output t_in_item o_item
);

    logic     r_valid;
    t_in_item r_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

endmodule

// File: src/vbp_pack_core.sv
// ----------------------------------------------------------------------------
// vbp_pack_core
// Pending byte state and the single-pass packing logic for one item.
// ----------------------------------------------------------------------------
module vbp_pack_core
    import vbp_pkg::*;
#(
    parameter int MAX_FIELD_BITS = MAX_FIELD_BITS_DEF,
    parameter int BUF_W          = 8 * ((MAX_FIELD_BITS + 7) / 8 + 1),
    parameter int NB_W           = $clog2((MAX_FIELD_BITS + 7) / 8 + 1)
)
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_in_item         i_item,
    input  logic             i_load,
    output logic [BUF_W-1:0] o_bytes,
    output logic [NB_W-1:0]  o_nbytes
);

    localparam int W     = MAX_FIELD_BITS;
    localparam int CS_W  = $clog2(W + 1);
    localparam int TOT_W = $clog2(W + 8);

    logic [BYTE_W-1:0] r_pending, n_pending;
    logic [2:0]        r_fill, n_fill;

    logic [CS_W-1:0]   count_sat;
    logic [W-1:0]      v_ext, v_rev, mask, stream;
    logic [BUF_W-1:0]  combined;
    logic [TOT_W-1:0]  total;

    always_comb begin
        if (32'(i_item.bit_count) > W) begin
            count_sat = CS_W'(W);
        end else begin
            count_sat = CS_W'(i_item.bit_count);
        end
        v_ext = W'(i_item.field_value);
        for (int j = 0; j < W; j++) begin
            v_rev[j] = v_ext[W-1-j];
        end
        mask = {W{1'b1}} >> (CS_W'(W) - count_sat);
        if (i_item.msb_first) begin
            stream = v_rev >> (CS_W'(W) - count_sat);
        end else begin
            stream = v_ext & mask;
        end
        combined = BUF_W'(r_pending) | (BUF_W'(stream) << r_fill);
        total    = TOT_W'(r_fill) + TOT_W'(count_sat);

        if (i_item.func == FUNC_FLUSH) begin
            o_bytes   = BUF_W'(r_pending);
            o_nbytes  = NB_W'(r_fill != 3'd0);
            n_pending = '0;
            n_fill    = '0;
        end else begin
            o_bytes   = combined;
            o_nbytes  = NB_W'(total >> 3);
            n_fill    = total[2:0];
            n_pending = BYTE_W'(combined >> {total[TOT_W-1:3], 3'b000});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
            r_fill    <= '0;
        end else if (i_load) begin
            r_pending <= n_pending;
            r_fill    <= n_fill;
        end
    end

    // Bits at and above the fill point stay clear
    a_pending_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pending >> r_fill) == '0)
        else $error("pending byte holds bits above fill point");

    // A flush never yields more than one byte and always restarts the byte
    a_flush_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_load && i_item.func == FUNC_FLUSH) |=> (r_fill == 3'd0 && $past(o_nbytes) <= 1))
        else $error("flush misbehaved");

    // A zero-length write leaves the state untouched
    a_zero_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_load && i_item.func == FUNC_WRITE && i_item.bit_count == '0)
        |=> ($stable(r_fill) && $stable(r_pending)))
        else $error("zero-length write changed state");

endmodule

// File: src/vbp_out_stage.sv
// ----------------------------------------------------------------------------
// vbp_out_stage
// Result register: holds the bytes of one item and sends them one per cycle while i_ready is high.
// ----------------------------------------------------------------------------
module vbp_out_stage
    import vbp_pkg::*;
#(
    parameter int BUF_W = 40,
    parameter int NB_W  = 3
)
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  logic [BUF_W-1:0]  i_bytes,
    input  logic [NB_W-1:0]   i_nbytes,
    output logic              o_can_load,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [BYTE_W-1:0] o_byte,
    output logic              o_last
);

    logic [BUF_W-1:0] r_buf;
    logic [NB_W-1:0]  r_cnt;

    assign o_valid    = r_cnt != '0;
    assign o_last     = r_cnt == NB_W'(1);
    assign o_byte     = r_buf[BYTE_W-1:0];
    assign o_can_load = (r_cnt == '0) || (o_last && i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= i_nbytes;
        end else if (o_valid && i_ready) begin
            r_cnt <= r_cnt - NB_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_buf <= i_bytes;
        end else if (o_valid && i_ready) begin
            r_buf <= r_buf >> BYTE_W;
        end
    end

endmodule

// File: src/variable_bit_packer_unit.sv
// ----------------------------------------------------------------------------
// variable_bit_packer_unit
// Packs variable-length bit fields (LSB or MSB order) into a byte stream.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata (low bit up)                         | tuser / tlast
//  s_axis   | in  | field_value[31:0] bit_count[37:32]         | tuser = func
//           |     | msb_first[38] zero[39]                     |
//  m_axis   | out | out_byte[7:0]                              | tlast = last_of_run
//
//  An item is packed in one pass between the input register and the result
//  register; the result register then sends one byte per cycle while m_axis
//  is ready. A write of n bits with f bits pending yields (f+n)/8 bytes, so a
//  full 32-bit write yields 4 bytes for the single-byte output port.
//  The next item is taken while the last byte of the previous one goes out.
//  Reset (synchronous, active low) clears the pending byte, the fill count
//  and both valid flags. A stalled m_axis holds the byte and backs up s_axis.
// ----------------------------------------------------------------------------
module variable_bit_packer_unit
    import vbp_pkg::*;
#(
    parameter int MAX_FIELD_BITS = MAX_FIELD_BITS_DEF
)
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_TDATA_W-1:0] s_axis_tdata,   // field_value, bit_count, msb_first, pad
    input  logic                  s_axis_tuser,   // func
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [BYTE_W-1:0]     m_axis_tdata,   // out_byte
    output logic                  m_axis_tlast
);

    localparam int BUF_W = 8 * ((MAX_FIELD_BITS + 7) / 8 + 1);
    localparam int NB_W  = $clog2((MAX_FIELD_BITS + 7) / 8 + 1);

    t_in_item         in_item, held_item;
    logic             held_valid;
    logic             can_load;
    logic             load;
    logic [BUF_W-1:0] pack_bytes;
    logic [NB_W-1:0]  pack_nbytes;

    // Unpack the slave word into item fields
    always_comb begin
        in_item.func        = s_axis_tuser;
        in_item.field_value = s_axis_tdata[VALUE_W-1:0];
        in_item.bit_count   = s_axis_tdata[VALUE_W +: BIT_COUNT_W];
        in_item.msb_first   = s_axis_tdata[VALUE_W + BIT_COUNT_W];
    end

    // Advance the held item into the result register once it can take it
    assign load = held_valid && can_load;

    vbp_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_item  (in_item),
        .i_take  (load),
        .o_valid (held_valid),
        .o_item  (held_item)
    );

    vbp_pack_core #(
        .MAX_FIELD_BITS (MAX_FIELD_BITS),
        .BUF_W          (BUF_W),
        .NB_W           (NB_W)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (held_item),
        .i_load   (load),
        .o_bytes  (pack_bytes),
        .o_nbytes (pack_nbytes)
    );

    vbp_out_stage #(
        .BUF_W (BUF_W),
        .NB_W  (NB_W)
    ) u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (load),
        .i_bytes    (pack_bytes),
        .i_nbytes   (pack_nbytes),
        .o_can_load (can_load),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_byte     (m_axis_tdata),
        .o_last     (m_axis_tlast)
    );

    // A held item that cannot advance must back-pressure the input
    a_hold_backs_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (held_valid && !load) |-> !s_axis_tready)
        else $error("input accepted while held item is blocked");

    // The byte stream only runs dry after the last word of a run was taken
    a_drain_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(m_axis_tvalid) |-> $past(m_axis_tlast && m_axis_tready))
        else $error("output went idle mid-run");

endmodule

// File: dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the variable bit packer. It streams directed and
// random write/flush words into s_axis and keeps its own bit-level model of
// the pending byte. It checks every m_axis byte and its tlast flag in order.
// ----------------------------------------------------------------------------
module testbench;
    import vbp_pkg::*;

    localparam int FIELD_CAP      = MAX_FIELD_BITS_DEF;
    localparam int RANDOM_WORDS   = 300;
    localparam int HOLD_AT        = 120;   // accepted input words before the long stall
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 20;

    typedef struct {
        t_in_item item;
        bit       wait_idle;   // hold this word back until no byte is outstanding
    } t_field_req;

    typedef struct {
        logic [BYTE_W-1:0] data;
        logic              last;
    } t_packed_byte;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_TDATA_W-1:0] s_axis_tdata  = '0;   // field_value, bit_count, msb_first, pad
    logic                  s_axis_tuser  = FUNC_WRITE;   // func
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [BYTE_W-1:0]     m_axis_tdata;          // out_byte
    logic                  m_axis_tlast;

    t_field_req   feed_q[$];
    t_packed_byte byte_q[$];

    // Own copy of the packing state
    logic [BYTE_W-1:0] acc_byte = '0;
    int                acc_fill = 0;

    logic in_fire     = 1'b0;
    bit   tx_busy     = 1'b0;
    int   tx_gap      = 0;
    int   rx_stall    = 0;
    int   hold_left   = 0;
    bit   hold_done   = 1'b0;
    int   n_taken     = 0;
    int   n_errors    = 0;
    int   idle_cycles = 0;

    variable_bit_packer_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Append the selected bits to the pending byte; queue every byte that
    // fills up, or the partial byte on a flush. The last one gets tlast.
    function automatic void predict_bytes(t_in_item it);
        int           n_bits;
        int           pos;
        int           k;
        int           first_new;
        t_packed_byte pb;
        first_new = byte_q.size();
        if (it.func == FUNC_FLUSH) begin
            if (acc_fill != 0) begin
                pb.data = acc_byte;
                pb.last = 1'b0;
                byte_q.push_back(pb);
                acc_byte = '0;
                acc_fill = 0;
            end
        end else begin
            n_bits = (it.bit_count > FIELD_CAP) ? FIELD_CAP : int'(it.bit_count);
            for (k = 0; k < n_bits; k++) begin
                pos = it.msb_first ? (n_bits - 1 - k) : k;
                acc_byte[acc_fill] = (pos < VALUE_W) ? it.field_value[pos] : 1'b0;
                acc_fill++;
                if (acc_fill == BYTE_W) begin
                    pb.data = acc_byte;
                    pb.last = 1'b0;
                    byte_q.push_back(pb);
                    acc_byte = '0;
                    acc_fill = 0;
                end
            end
        end
        if (byte_q.size() > first_new)
            byte_q[byte_q.size() - 1].last = 1'b1;
    endfunction

    function automatic void add_word(logic func, logic [VALUE_W-1:0] value,
                                     logic [BIT_COUNT_W-1:0] count, logic msb,
                                     bit wait_idle);
        t_field_req req;
        req.item.func        = func;
        req.item.field_value = value;
        req.item.bit_count   = count;
        req.item.msb_first   = msb;
        req.wait_idle        = wait_idle;
        feed_q.push_back(req);
    endfunction

    // Stretches of full rate on both sides, keyed to input progress
    function automatic bit calm_phase();
        return ((n_taken / 40) % 4) == 2;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (hold_left > 0 || calm_phase() || r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    // Sender: present the next word at the falling edge, hold it until taken
    always @(negedge i_clk) begin
        t_field_req cur;
        if (i_rst_n) begin
            if (in_fire)
                tx_busy = 1'b0;
            if (!tx_busy) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                end else if (feed_q.size() > 0 &&
                             (!feed_q[0].wait_idle || byte_q.size() == 0)) begin
                    cur = feed_q.pop_front();
                    s_axis_tdata <= {1'b0, cur.item.msb_first, cur.item.bit_count,
                                     cur.item.field_value};
                    s_axis_tuser <= cur.item.func;
                    tx_busy = 1'b1;
                    tx_gap  = pick_gap();
                end
            end
            s_axis_tvalid <= tx_busy;
        end
    end

    // Receiver: random stalls, one long hold-off to back the block up
    always @(negedge i_clk) begin
        int r;
        bit rx_ready;
        if (i_rst_n) begin
            if (!hold_done && n_taken >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            rx_ready = 1'b0;
            if (hold_left > 0) begin
                hold_left--;
            end else if (rx_stall > 0) begin
                rx_stall--;
            end else if (calm_phase()) begin
                rx_ready = 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 70)
                    rx_ready = 1'b1;
                else if (r < 95)
                    rx_stall = $urandom_range(0, 2);
                else
                    rx_stall = $urandom_range(10, 40);
            end
            m_axis_tready <= rx_ready;
        end
    end

    // Monitor: predict on every taken input word, check every output byte
    always @(posedge i_clk) begin
        t_in_item     it;
        t_packed_byte exp_b;
        bit           moved;
        in_fire <= i_rst_n && s_axis_tvalid && s_axis_tready;
        if (i_rst_n) begin
            moved = 1'b0;
            if (s_axis_tvalid && s_axis_tready) begin
                it.func        = s_axis_tuser;
                it.field_value = s_axis_tdata[VALUE_W-1:0];
                it.bit_count   = s_axis_tdata[VALUE_W +: BIT_COUNT_W];
                it.msb_first   = s_axis_tdata[VALUE_W + BIT_COUNT_W];
                predict_bytes(it);
                n_taken++;
                moved = 1'b1;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                moved = 1'b1;
                if (byte_q.size() == 0) begin
                    $display("%0t: unexpected byte data=%h last=%b", $time,
                             m_axis_tdata, m_axis_tlast);
                    n_errors++;
                end else begin
                    exp_b = byte_q.pop_front();
                    if (m_axis_tdata !== exp_b.data) begin
                        $display("%0t: byte mismatch expected=%h actual=%h", $time,
                                 exp_b.data, m_axis_tdata);
                        n_errors++;
                    end
                    if (m_axis_tlast !== exp_b.last) begin
                        $display("%0t: tlast mismatch expected=%b actual=%b", $time,
                                 exp_b.last, m_axis_tlast);
                        n_errors++;
                    end
                end
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no word moved for %0d cycles", $time, idle_cycles);
                $display("testbench: FAIL");
                $finish;
            end
        end
    end

    initial begin
        int i;
        int r;
        int c;
        logic [VALUE_W-1:0]     v;
        logic [BIT_COUNT_W-1:0] cnt;

        // Directed: zero count, empty flush, full-width fields both orders
        add_word(FUNC_WRITE, 32'hFFFF_FFFF, 6'd0, 1'b1, 1'b0);
        add_word(FUNC_FLUSH, 32'h0, 6'd0, 1'b0, 1'b0);
        add_word(FUNC_WRITE, 32'hFFFF_FFFF, 6'd32, 1'b0, 1'b0);
        add_word(FUNC_WRITE, 32'h0000_0000, 6'd32, 1'b1, 1'b0);
        add_word(FUNC_WRITE, 32'hA5C3_0F81, 6'd32, 1'b0, 1'b0);
        add_word(FUNC_WRITE, 32'hA5C3_0F81, 6'd32, 1'b1, 1'b0);
        // Partial byte, zero count while bits are pending, then flushes
        add_word(FUNC_WRITE, 32'h0000_0005, 6'd3, 1'b0, 1'b0);
        add_word(FUNC_WRITE, 32'hFFFF_FFFF, 6'd0, 1'b1, 1'b0);
        add_word(FUNC_FLUSH, 32'h0, 6'd0, 1'b0, 1'b0);
        add_word(FUNC_FLUSH, 32'h0, 6'd0, 1'b0, 1'b0);
        // Oversized counts saturate at the field cap
        add_word(FUNC_WRITE, 32'hFFFF_FFFF, 6'd63, 1'b1, 1'b0);
        add_word(FUNC_WRITE, 32'h8000_0001, 6'd33, 1'b0, 1'b0);
        add_word(FUNC_WRITE, 32'h1234_5678, 6'd40, 1'b1, 1'b0);
        // Flush operands must be ignored
        add_word(FUNC_WRITE, 32'h0000_0013, 6'd5, 1'b1, 1'b0);
        add_word(FUNC_FLUSH, 32'hFFFF_FFFF, 6'd63, 1'b1, 1'b0);
        // Fields that straddle byte boundaries
        add_word(FUNC_WRITE, 32'h0000_0001, 6'd1, 1'b0, 1'b0);
        add_word(FUNC_WRITE, 32'h0000_007F, 6'd7, 1'b1, 1'b0);
        add_word(FUNC_WRITE, 32'h0000_1ABC, 6'd13, 1'b1, 1'b0);
        add_word(FUNC_WRITE, 32'h0000_05A5, 6'd11, 1'b0, 1'b0);
        add_word(FUNC_WRITE, 32'h0000_00FF, 6'd8, 1'b0, 1'b0);
        add_word(FUNC_FLUSH, 32'h0, 6'd0, 1'b0, 1'b0);
        add_word(FUNC_WRITE, 32'h8000_0000, 6'd32, 1'b1, 1'b1);

        // Random: mostly writes of every size, some flushes with junk operands
        for (i = 0; i < RANDOM_WORDS; i++) begin
            r = $urandom_range(0, 99);
            c = $urandom_range(0, 99);
            if (c < 10)
                cnt = 6'd0;
            else if (c < 20)
                cnt = BIT_COUNT_W'($urandom_range(33, 63));
            else if (c < 40)
                cnt = 6'd32;
            else
                cnt = BIT_COUNT_W'($urandom_range(1, 31));
            c = $urandom_range(0, 9);
            v = (c == 0) ? 32'h0 : (c == 1) ? 32'hFFFF_FFFF : VALUE_W'($urandom);
            add_word((r < 12) ? FUNC_FLUSH : FUNC_WRITE, v, cnt, 1'($urandom_range(0, 1)),
                     (i == 150) || ($urandom_range(0, 99) < 2));
        end

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (feed_q.size() != 0 || tx_busy)
            @(posedge i_clk);
        while (byte_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (n_errors == 0 && byte_q.size() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
